[rtl/shifted_kmer_mismatch_match_assert.svh]
// assertion macros shared by the matcher rtl
// both expect i_clk and i_rst_n in the scope of use
`ifndef SHIFTED_KMER_MISMATCH_MATCH_ASSERT_SVH
`define SHIFTED_KMER_MISMATCH_MATCH_ASSERT_SVH

// same-cycle implication
`define SKMM_ASSERT_IMPL(lbl, ante, cons) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error("skmm: same-cycle check failed");

// next-cycle implication
`define SKMM_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error("skmm: next-cycle check failed");

`endif

[rtl/skmm_pkg.sv]
// ----------------------------------------------------------------------------
// skmm_pkg
// Shared sizes, codes and types of the shifted k-mer mismatch matcher.
// ----------------------------------------------------------------------------
package skmm_pkg;

    // store sizes
    localparam int SEQ_LEN  = 64;
    localparam int MAX_KMER = 8;
    localparam int CB_DEPTH = 256;

    localparam int SEQ_AW = $clog2(SEQ_LEN);
    localparam int CB_AW  = $clog2(CB_DEPTH * MAX_KMER);
    localparam int CHAR_W = $clog2(MAX_KMER);
    localparam int CNT_W  = $clog2(MAX_KMER + 1);

    // field widths
    localparam int REQ_W  = 2;
    localparam int POS_W  = 6;
    localparam int ENT_W  = 8;
    localparam int CH_W   = 3;
    localparam int SYM_W  = 8;
    localparam int FIDX_W = 21;
    localparam int K_W    = 4;
    localparam int SH_W   = 4;
    localparam int LIM_W  = 4;
    localparam int NENT_W = 9;
    localparam int OFF_W  = 20;
    localparam int CIDX_W = 3;
    localparam int CDAT_W = 20;
    localparam int PROD_W = POS_W + NENT_W;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_SEQ  = 2'd0,
        REQ_LOAD_CODE = 2'd1,
        REQ_QUERY     = 2'd2,
        REQ_UNUSED    = 2'd3
    } t_req;

    // register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_KMER_LENGTH = 3'd0,
        CFG_SHIFT_SPAN  = 3'd1,
        CFG_MISMATCH    = 3'd2,
        CFG_ENTRIES     = 3'd3,
        CFG_DIM_OFFSET  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [K_W-1:0]    kmer_length;
        logic [SH_W-1:0]   shift_span;
        logic [LIM_W-1:0]  limit;
        logic [NENT_W-1:0] entries;
        logic [OFF_W-1:0]  offset;
    } t_cfg;

    // classified work for the back end
    typedef enum logic [1:0] {
        CMD_SEQ,
        CMD_CODE,
        CMD_QUERY
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               bad;
        logic [POS_W-1:0]   pos;
        logic [ENT_W-1:0]   entry;
        logic [CH_W-1:0]    ch;
        logic [SYM_W-1:0]   sym;
        logic [FIDX_W-1:0]  fidx;
    } t_cmd;

    // back end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WORD,
        ST_PICK,
        ST_CMP,
        ST_DONE
    } t_state;

endpackage

[rtl/skmm_if.sv]
// ----------------------------------------------------------------------------
// skmm_if
// Handshake channels of the matcher: requests, results and register writes.
// ----------------------------------------------------------------------------
interface skmm_req_if import skmm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [POS_W-1:0]  seq_pos;
    logic [ENT_W-1:0]  code_entry;
    logic [CH_W-1:0]   code_char;
    logic [SYM_W-1:0]  symbol;

    modport source (output valid, req_type, seq_pos, code_entry, code_char, symbol,
                    input ready);
    modport sink   (input valid, req_type, seq_pos, code_entry, code_char, symbol,
                    output ready);
endinterface

interface skmm_res_if import skmm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              hit;
    logic [FIDX_W-1:0] feature_index;
    logic              bad_query;

    modport source (output valid, hit, feature_index, bad_query, input ready);
    modport sink   (input valid, hit, feature_index, bad_query, output ready);
endinterface

interface skmm_cfg_if import skmm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [CDAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/skmm_ram.sv]
// ----------------------------------------------------------------------------
// skmm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module skmm_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/skmm_front.sv]
// ----------------------------------------------------------------------------
// skmm_front
// Accepts request items, drops ignored ones and precomputes query checks
// and the feature index.
// ----------------------------------------------------------------------------
module skmm_front import skmm_pkg::*; (
    skmm_req_if.sink   i_req,
    input  t_cfg       i_cfg,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic              w_accept;
    logic              w_keep;
    logic              w_bad;
    logic [PROD_W-1:0] w_prod;
    logic [FIDX_W-1:0] w_fidx;

    assign i_req.ready = !i_full;
    assign w_accept    = i_req.valid && i_req.ready;

    // range checks of a query
    assign w_bad = (i_cfg.kmer_length == '0) ||
                   (int'(i_cfg.kmer_length) > MAX_KMER) ||
                   (int'(i_req.seq_pos) + int'(i_cfg.kmer_length) > SEQ_LEN) ||
                   ({1'b0, i_req.code_entry} >= i_cfg.entries) ||
                   (int'(i_req.code_entry) >= CB_DEPTH);

    // one-based feature index, wraps at the field width
    assign w_prod = PROD_W'(i_req.seq_pos) * PROD_W'(i_cfg.entries);
    assign w_fidx = FIDX_W'(i_cfg.offset) + FIDX_W'(w_prod)
                  + FIDX_W'(i_req.code_entry) + FIDX_W'(1);

    // classify the item
    always_comb begin
        o_cmd       = '0;
        o_cmd.pos   = i_req.seq_pos;
        o_cmd.entry = i_req.code_entry;
        o_cmd.ch    = i_req.code_char;
        o_cmd.sym   = i_req.symbol;
        w_keep      = 1'b0;
        unique case (t_req'(i_req.req_type))
            REQ_LOAD_SEQ: begin
                o_cmd.kind = CMD_SEQ;
                w_keep     = int'(i_req.seq_pos) < SEQ_LEN;
            end
            REQ_LOAD_CODE: begin
                o_cmd.kind = CMD_CODE;
                w_keep     = (int'(i_req.code_entry) < CB_DEPTH) &&
                             (int'(i_req.code_char) < MAX_KMER);
            end
            REQ_QUERY: begin
                o_cmd.kind = CMD_QUERY;
                o_cmd.bad  = w_bad;
                o_cmd.fidx = w_bad ? '0 : w_fidx;
                w_keep     = 1'b1;
            end
            default: begin
                o_cmd.kind = CMD_SEQ;
                w_keep     = 1'b0;
            end
        endcase
    end

    assign o_push = w_accept && w_keep;

endmodule

[rtl/skmm_queue.sv]
// ----------------------------------------------------------------------------
// skmm_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module skmm_queue import skmm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, n_wp;
    logic [Q_AW-1:0] r_rp, n_rp;
    logic [Q_CW-1:0] r_cnt, n_cnt;

    assign o_full  = r_cnt == Q_CW'(Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_mem[r_rp];

    // pointer and fill updates
    always_comb begin
        n_wp  = i_push ? r_wp + Q_AW'(1) : r_wp;
        n_rp  = i_pop  ? r_rp + Q_AW'(1) : r_rp;
        n_cnt = r_cnt + Q_CW'(i_push) - Q_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

[rtl/skmm_back.sv]
// ----------------------------------------------------------------------------
// skmm_back
// Executes loads into the stores and runs queries: fetches the codebook word,
// then compares shifted windows one character a cycle.
// ----------------------------------------------------------------------------
module skmm_back import skmm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_empty,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    skmm_res_if.source  o_res
);

    t_state            r_state, n_state;
    t_cmd              r_cmd;
    logic [SH_W-1:0]   r_s, n_s;
    logic              r_minus, n_minus;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_diff, n_diff;
    logic [SEQ_AW-1:0] r_base, n_base;
    logic              r_hit, n_hit;
    logic [SYM_W-1:0]  r_word [MAX_KMER];
    logic              r_out_vld;
    logic              r_out_hit;
    logic [FIDX_W-1:0] r_out_fidx;
    logic              r_out_bad;
    logic              r_load_vld;

    logic              w_seq_we, w_code_we;
    logic [SEQ_AW-1:0] w_seq_raddr;
    logic [CB_AW-1:0]  w_code_waddr, w_code_raddr;
    logic [SYM_W-1:0]  w_seq_rdata, w_code_rdata;
    logic [CNT_W-1:0]  w_k;
    logic [CHAR_W-1:0] w_prev;
    logic              w_issue_end;
    logic              w_plus_ok, w_minus_ok, w_win_ok;
    logic [SEQ_AW-1:0] w_win_base;
    logic              w_last_win;
    logic [CNT_W-1:0]  w_diff_sum;
    logic              w_match;
    logic              w_out_free;
    logic              w_word_we;

    // stores
    skmm_ram #(.W(SYM_W), .D(SEQ_LEN)) u_seq_ram (
        .i_clk   (i_clk),
        .i_we    (w_seq_we),
        .i_waddr (r_cmd.pos[SEQ_AW-1:0]),
        .i_wdata (r_cmd.sym),
        .i_raddr (w_seq_raddr),
        .o_rdata (w_seq_rdata)
    );

    skmm_ram #(.W(SYM_W), .D(CB_DEPTH * MAX_KMER)) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (w_code_we),
        .i_waddr (w_code_waddr),
        .i_wdata (r_cmd.sym),
        .i_raddr (w_code_raddr),
        .o_rdata (w_code_rdata)
    );

    // shared terms
    assign w_k         = CNT_W'(i_cfg.kmer_length);
    assign w_prev      = CHAR_W'(r_cnt - CNT_W'(1));
    assign w_issue_end = r_cnt == w_k;
    assign w_out_free  = !r_out_vld || o_res.ready;

    // window selection for the current shift and side
    assign w_plus_ok  = int'(r_cmd.pos) + int'(r_s) + int'(i_cfg.kmer_length) <= SEQ_LEN;
    assign w_minus_ok = {1'b0, r_cmd.pos} >= (POS_W + 1)'(r_s);
    assign w_win_ok   = r_minus ? w_minus_ok : w_plus_ok;
    assign w_win_base = r_minus ? SEQ_AW'(r_cmd.pos - POS_W'(r_s))
                                : SEQ_AW'(r_cmd.pos + POS_W'(r_s));
    assign w_last_win = r_minus && (r_s == i_cfg.shift_span);

    // mismatch count including the character arriving now
    assign w_diff_sum = r_diff + CNT_W'(w_seq_rdata != r_word[w_prev]);
    assign w_match    = int'(w_diff_sum) <= int'(i_cfg.limit);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty && (i_cmd.kind == CMD_QUERY)) begin
                    n_state = i_cmd.bad ? ST_DONE : ST_WORD;
                end
            end
            ST_WORD: begin
                if (w_issue_end) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                if (w_win_ok) begin
                    n_state = ST_CMP;
                end else if (w_last_win) begin
                    n_state = ST_DONE;
                end
            end
            ST_CMP: begin
                if (w_issue_end) begin
                    n_state = (w_match || w_last_win) ? ST_DONE : ST_PICK;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        o_pop        = 1'b0;
        w_word_we    = 1'b0;
        w_code_waddr = CB_AW'(int'(r_cmd.entry) * MAX_KMER + int'(r_cmd.ch));
        w_code_raddr = CB_AW'(int'(r_cmd.entry) * MAX_KMER + int'(r_cnt));
        w_seq_raddr  = SEQ_AW'(r_base + SEQ_AW'(r_cnt));
        n_s          = r_s;
        n_minus      = r_minus;
        n_cnt        = r_cnt;
        n_diff       = r_diff;
        n_base       = r_base;
        n_hit        = r_hit;
        unique case (r_state)
            ST_IDLE: begin
                o_pop   = !i_empty;
                n_s     = '0;
                n_minus = 1'b0;
                n_cnt   = '0;
                n_diff  = '0;
                n_hit   = 1'b0;
            end
            ST_WORD: begin
                n_cnt     = w_issue_end ? '0 : r_cnt + CNT_W'(1);
                w_word_we = r_cnt != '0;
            end
            ST_PICK: begin
                n_cnt  = '0;
                n_diff = '0;
                n_base = w_win_base;
                if (!w_win_ok && !w_last_win) begin
                    n_minus = !r_minus;
                    n_s     = r_minus ? r_s + SH_W'(1) : r_s;
                end
            end
            ST_CMP: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt != '0) begin
                    n_diff = w_diff_sum;
                end
                if (w_issue_end) begin
                    n_hit   = w_match;
                    n_minus = !r_minus;
                    n_s     = r_minus ? r_s + SH_W'(1) : r_s;
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // result channel
    assign o_res.valid         = r_out_vld;
    assign o_res.hit           = r_out_hit;
    assign o_res.feature_index = r_out_fidx;
    assign o_res.bad_query     = r_out_bad;

    // load execution register: holds the popped load for one write cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_vld <= 1'b0;
        end else begin
            r_load_vld <= o_pop && (i_cmd.kind != CMD_QUERY);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        r_s     <= n_s;
        r_minus <= n_minus;
        r_cnt   <= n_cnt;
        r_diff  <= n_diff;
        r_base  <= n_base;
        r_hit   <= n_hit;
        if (w_word_we) begin
            r_word[w_prev] <= w_code_rdata;
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out_hit  <= r_hit && !r_cmd.bad;
            r_out_fidx <= r_cmd.fidx;
            r_out_bad  <= r_cmd.bad;
        end
    end

    // loads are written the cycle after they leave the queue
    assign w_seq_we  = r_load_vld && (r_cmd.kind == CMD_SEQ);
    assign w_code_we = r_load_vld && (r_cmd.kind == CMD_CODE);

`include "shifted_kmer_mismatch_match_assert.svh"

    `SKMM_ASSERT_IMPL(a_cnt_range, r_state == ST_CMP, r_cnt <= w_k)
    `SKMM_ASSERT_IMPL(a_bad_no_hit, r_out_vld && r_out_bad, !r_out_hit && (r_out_fidx == '0))
    `SKMM_ASSERT_NEXT(a_load_stays_idle,
        (r_state == ST_IDLE) && !i_empty && (i_cmd.kind != CMD_QUERY), r_state == ST_IDLE)

endmodule

[rtl/shifted_kmer_mismatch_match.sv]
// ----------------------------------------------------------------------------
// shifted_kmer_mismatch_match
// Sequence store plus k-mer codebook; answers shifted mismatch queries.
// ----------------------------------------------------------------------------
// Loads execute in the back end without leaving its idle state. A query
// fetches the codebook word, then takes a selection step per candidate window
// and a character compare of each window inside the sequence, trying up to
// 2*(shift span+1) windows and stopping at the first match; a bad query goes
// straight to its result. The single read port of the sequence RAM limits the
// compare to one character a cycle. A four-item queue lets requests be taken
// while a query runs; a result register lets work go on while a result waits.
module shifted_kmer_mismatch_match import skmm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    skmm_req_if.sink   i_req,
    skmm_cfg_if.sink   i_cfg,
    skmm_res_if.source o_res
);

    t_cfg r_cfg;
    logic w_push, w_full, w_pop, w_empty;
    t_cmd w_push_cmd, w_pop_cmd;

    assign i_cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{kmer_length: K_W'(1), default: '0};
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_KMER_LENGTH: r_cfg.kmer_length <= i_cfg.data[K_W-1:0];
                CFG_SHIFT_SPAN:  r_cfg.shift_span  <= i_cfg.data[SH_W-1:0];
                CFG_MISMATCH:    r_cfg.limit       <= i_cfg.data[LIM_W-1:0];
                CFG_ENTRIES:     r_cfg.entries     <= i_cfg.data[NENT_W-1:0];
                CFG_DIM_OFFSET:  r_cfg.offset      <= i_cfg.data[OFF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    skmm_front u_front (
        .i_req  (i_req),
        .i_cfg  (r_cfg),
        .i_full (w_full),
        .o_push (w_push),
        .o_cmd  (w_push_cmd)
    );

    skmm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_pop_cmd),
        .o_empty (w_empty)
    );

    skmm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (w_empty),
        .i_cmd   (w_pop_cmd),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

[tb/skmm_test_if.sv]
// ----------------------------------------------------------------------------
// skmm_test_if
// The test build shares the handshake channel interfaces of the rtl folder;
// no separate channel definitions are kept here.
// ----------------------------------------------------------------------------

[tb/shifted_kmer_mismatch_match_checker.sv]
// ----------------------------------------------------------------------------
// shifted_kmer_mismatch_match_checker
// Watches the request, register and result channels, predicts each query
// result from a shadow of the stores and registers, and compares in order.
// ----------------------------------------------------------------------------
module shifted_kmer_mismatch_match_checker import skmm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    skmm_req_if         i_req,
    skmm_cfg_if         i_cfg,
    skmm_res_if         i_res,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic              hit;
        logic [FIDX_W-1:0] fidx;
        logic              bad;
    } t_answer;

    logic [SYM_W-1:0] seq_shadow [SEQ_LEN];
    logic [SYM_W-1:0] word_shadow [CB_DEPTH*MAX_KMER];
    t_cfg             regs;
    t_answer          answers_due [$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        o_errors++;
    endtask

    // count of differing characters within the limit
    function automatic bit window_close(input int start, input int entry);
        int diff;
        diff = 0;
        for (int c = 0; c < regs.kmer_length; c++)
            if (seq_shadow[start+c] !== word_shadow[entry*MAX_KMER+c])
                diff++;
        return diff <= regs.limit;
    endfunction

    function automatic t_answer answer_query(input int pos, input int entry);
        t_answer a;
        int k;
        a = '0;
        k = regs.kmer_length;
        if (k == 0 || k > MAX_KMER || pos + k > SEQ_LEN ||
            entry >= regs.entries || entry >= CB_DEPTH) begin
            a.bad = 1'b1;
            return a;
        end
        for (int s = 0; s <= regs.shift_span && !a.hit; s++) begin
            if (pos + s + k <= SEQ_LEN && window_close(pos + s, entry))
                a.hit = 1'b1;
            else if (pos >= s && window_close(pos - s, entry))
                a.hit = 1'b1;
        end
        a.fidx = FIDX_W'(regs.offset + pos * regs.entries + entry + 1);
        return a;
    endfunction

    // sample all channels at the rising edge
    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            regs = '{kmer_length: K_W'(1), default: '0};
            answers_due.delete();
            o_errors = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_KMER_LENGTH: regs.kmer_length = i_cfg.data[K_W-1:0];
                    CFG_SHIFT_SPAN:  regs.shift_span = i_cfg.data[SH_W-1:0];
                    CFG_MISMATCH:    regs.limit = i_cfg.data[LIM_W-1:0];
                    CFG_ENTRIES:     regs.entries = i_cfg.data[NENT_W-1:0];
                    CFG_DIM_OFFSET:  regs.offset = i_cfg.data[OFF_W-1:0];
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                case (i_req.req_type)
                    REQ_LOAD_SEQ:  seq_shadow[i_req.seq_pos] = i_req.symbol;
                    REQ_LOAD_CODE: word_shadow[int'(i_req.code_entry)*MAX_KMER
                                               + int'(i_req.code_char)] = i_req.symbol;
                    REQ_QUERY:     answers_due.push_back(answer_query(
                                       int'(i_req.seq_pos), int'(i_req.code_entry)));
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                if (answers_due.size() == 0) begin
                    report("unexpected result", 32'd0, 32'd0);
                end else begin
                    want = answers_due.pop_front();
                    if (i_res.hit !== want.hit)
                        report("hit", 32'(i_res.hit), 32'(want.hit));
                    if (i_res.feature_index !== want.fidx)
                        report("feature_index", 32'(i_res.feature_index), 32'(want.fidx));
                    if (i_res.bad_query !== want.bad)
                        report("bad_query", 32'(i_res.bad_query), 32'(want.bad));
                end
            end
        end
        o_pending = answers_due.size();
    end

endmodule

[tb/shifted_kmer_mismatch_match_test.sv]
// ----------------------------------------------------------------------------
// shifted_kmer_mismatch_match_test
// Loads sequence and codebook, runs directed and random queries over several
// register settings with random bursts and stalls; the checker judges results.
// ----------------------------------------------------------------------------
module shifted_kmer_mismatch_match_test;
    import skmm_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;
    int   cycles = 0;
    bit   hold_off = 1'b0;
    bit   codebook_written [CB_DEPTH];

    skmm_req_if req_ch ();
    skmm_cfg_if cfg_ch ();
    skmm_res_if res_ch ();

    shifted_kmer_mismatch_match dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_res   (res_ch.source)
    );

    shifted_kmer_mismatch_match_checker checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .i_cfg     (cfg_ch),
        .i_res     (res_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #1 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stalls on its own pattern, plus one long hold-off
    always @(negedge i_clk) begin
        int mode;
        mode = (cycles / 3000) % 3;
        if (hold_off)
            res_ch.ready <= 1'b0;
        else if (mode == 0)
            res_ch.ready <= 1'b1;
        else if (mode == 1)
            res_ch.ready <= ($urandom_range(0, 3) != 0);
        else
            res_ch.ready <= ($urandom_range(0, 3) == 0);
    end

    initial begin
        repeat (2000) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // one register write; the caller drops valid after the last one
    task automatic write_reg(input t_cfg_idx idx, input logic [CDAT_W-1:0] value);
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    // one item, with a random gap after bursts
    task automatic send(input t_req kind, input int pos, input int entry,
                        input int ch, input int sym);
        req_ch.req_type   <= kind;
        req_ch.seq_pos    <= POS_W'(pos);
        req_ch.code_entry <= ENT_W'(entry);
        req_ch.code_char  <= CH_W'(ch);
        req_ch.symbol     <= SYM_W'(sym);
        req_ch.valid      <= 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        if ($urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic load_word(input int entry, input bit similar);
        for (int c = 0; c < MAX_KMER; c++)
            send(REQ_LOAD_CODE, 0, entry, c,
                 similar ? $urandom_range(0, 3) : $urandom_range(0, 255));
        codebook_written[entry] = 1'b1;
    endtask

    // query only words already loaded, or out-of-range entries
    task automatic random_query(input int entries);
        int entry;
        entry = $urandom_range(0, CB_DEPTH - 1);
        if (entry < entries && !codebook_written[entry])
            entry = 0;
        send(REQ_QUERY, $urandom_range(0, SEQ_LEN - 1), entry, $urandom_range(0, 7),
             $urandom_range(0, 255));
    endtask

    task automatic set_regs(input int k, input int sh, input int lim, input int n,
                            input int off);
        write_reg(CFG_KMER_LENGTH, CDAT_W'(k));
        write_reg(CFG_SHIFT_SPAN, CDAT_W'(sh));
        write_reg(CFG_MISMATCH, CDAT_W'(lim));
        write_reg(CFG_ENTRIES, CDAT_W'(n));
        write_reg(CFG_DIM_OFFSET, CDAT_W'(off));
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_LOAD_SEQ;
        req_ch.seq_pos = '0;
        req_ch.code_entry = '0;
        req_ch.code_char = '0;
        req_ch.symbol = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_KMER_LENGTH;
        cfg_ch.data = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: fill the sequence, load extreme words, edge queries
        for (int p = 0; p < SEQ_LEN; p++)
            send(REQ_LOAD_SEQ, p, 0, 0, $urandom_range(0, 3));
        send(REQ_LOAD_SEQ, 5, 0, 0, 8'hff);
        send(REQ_LOAD_SEQ, 6, 0, 0, 8'h00);
        load_word(0, 1'b1);
        load_word(CB_DEPTH - 1, 1'b0);
        send(REQ_LOAD_CODE, 0, CB_DEPTH - 1, MAX_KMER - 1, 8'hff);
        send(REQ_UNUSED, 63, 255, 7, 255);
        drain();
        set_regs(MAX_KMER, 15, 8, 256, 20'hfffff);
        send(REQ_QUERY, 0, 0, 0, 0);
        send(REQ_QUERY, SEQ_LEN - MAX_KMER, CB_DEPTH - 1, 0, 0);
        send(REQ_QUERY, SEQ_LEN - MAX_KMER + 1, 0, 0, 0);
        drain();
        set_regs(0, 0, 0, 1, 0);
        send(REQ_QUERY, 0, 0, 0, 0);
        drain();
        set_regs(9, 0, 0, 1, 0);
        send(REQ_QUERY, 0, 0, 0, 0);
        drain();
        set_regs(15, 0, 0, 1, 0);
        send(REQ_QUERY, 0, 0, 0, 0);
        drain();
        set_regs(1, 0, 0, 0, 0);
        send(REQ_QUERY, 0, 0, 0, 0);
        drain();

        // random phases: loads of similar words, queries, noise
        for (int phase = 0; phase < 8; phase++) begin
            int k;
            int n;
            k = (phase == 0) ? 1 : (phase == 1) ? MAX_KMER : $urandom_range(1, MAX_KMER);
            n = (phase == 2) ? 256 : $urandom_range(1, 256);
            set_regs(k, (phase == 3) ? 15 : $urandom_range(0, 15),
                     (phase == 4) ? 8 : $urandom_range(0, 3), n,
                     (phase == 5) ? 20'hfffff : $urandom_range(0, 20'hfffff));
            for (int i = 0; i < 130; i++) begin
                int r;
                r = $urandom_range(0, 19);
                if (r < 2)
                    load_word($urandom_range(0, CB_DEPTH - 1), $urandom_range(0, 3) != 0);
                else if (r < 4)
                    send(REQ_LOAD_SEQ, $urandom_range(0, 63), 0, 0, $urandom_range(0, 3));
                else if (r == 4)
                    send(REQ_UNUSED, $urandom_range(0, 63), $urandom_range(0, 255),
                         $urandom_range(0, 7), $urandom_range(0, 255));
                else
                    random_query(n);
            end
            drain();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
